>>> sv/kvt_pkg.sv
// Shared types and constants for the keyed entry table.
package kvt_pkg;

	// Field widths fixed by the word format.
	localparam int KEY_W      = 32;
	localparam int NAME_W     = 64;
	localparam int CFG_W      = 7;
	localparam int ACT_W      = 2;
	localparam int STATUS_W   = 3;
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_PAD_W  = OUT_DATA_W - NAME_W - STATUS_W;

	// Capacity register value after reset.
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// Operation codes.
	typedef enum logic [ACT_W-1:0] {
		ACT_ADD = 2'd0,
		ACT_DEL = 2'd1,
		ACT_GET = 2'd2,
		ACT_UPD = 2'd3
	} action_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_FULL        = 3'd1,
		ST_DUP         = 3'd2,
		ST_NOT_FOUND   = 3'd3,
		ST_UPD_MISSING = 3'd4,
		ST_UPD_CLASH   = 3'd5
	} status_t;

	// One table entry as held in the entry memory.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [NAME_W-1:0] name;
	} entry_t;

endpackage

>>> sv/kvt_mem.sv
// Entry memory: one write port and one registered read port.
module kvt_mem #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  kvt_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output kvt_pkg::entry_t rdata
);
	import kvt_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data registered.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/keyed_entry_table_core.sv
// Top level of the keyed entry table: sequencer, scan compare unit and result register.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser: action; tdata: entry_key, new_key, entry_name
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: status, found_name
//  cfg       in   cfg_we                        cfg_wdata: capacity_in_use
//
// Add, get and update register their result once the scan of the stored entries ends; a
// delete first shifts the later entries down. The next word is accepted from the cycle after.
// The single read port of the entry memory sets the pace: the scan compares one
// stored key per cycle, and the delete shift moves one entry per cycle.
// An add to a full table skips the scan. The memory needs no clearing pass after reset.
// A new word is accepted only when the sequencer is idle; a result waiting in the output
// register does not block acceptance of the next word, only the finish of that word.
module keyed_entry_table_core #(
	parameter int CAPACITY = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration: capacity_in_use.
	input  logic                           cfg_we,
	input  logic [kvt_pkg::CFG_W-1:0]      cfg_wdata,
	// Input words.
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// From bit 0: entry_key[31:0], new_key[63:32], entry_name[127:64].
	input  logic [kvt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// From bit 0: action[1:0].
	input  logic [kvt_pkg::ACT_W-1:0]      s_axis_tuser,
	// Result words.
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// From bit 0: status[2:0], found_name[66:3], zero padding[71:67].
	output logic [kvt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import kvt_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > CFG_W) ? CW : CFG_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   cap_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      iss_q;
	logic               rd_v_s1;
	logic [AW-1:0]      rd_idx_s1;
	action_t            act_q;
	logic [KEY_W-1:0]   key_q;
	logic [KEY_W-1:0]   nkey_q;
	logic [NAME_W-1:0]  name_q;
	logic               hit_q;
	logic               clash_q;
	logic [AW-1:0]      hit_idx_q;
	logic [NAME_W-1:0]  found_q;
	status_t            res_status_q;
	logic [NAME_W-1:0]  res_name_q;
	logic               m_valid_q;
	status_t            m_status_q;
	logic [NAME_W-1:0]  m_name_q;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	entry_t             mem_wdata;
	logic [AW-1:0]      mem_raddr;
	entry_t             mem_rdata;

	logic               key_eq;
	logic               nkey_eq;
	logic               scan_hit;
	logic               issue_now;
	logic               sweep_end;
	logic [LW-1:0]      limit;
	logic               table_full;

	kvt_mem #(
		.DEPTH (CAPACITY)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Shared compare unit: the word just read against both request keys.
	assign key_eq   = (mem_rdata.key == key_q);
	assign nkey_eq  = (mem_rdata.key == nkey_q);
	assign scan_hit = rd_v_s1 && (act_q != ACT_UPD) && key_eq;

	// The limit in use is the register clamped to the built capacity.
	assign limit      = (LW'(cap_q) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(cap_q);
	assign table_full = (LW'(cnt_q) >= limit);

	// Read issue: one address a cycle while sweeping the valid entries.
	assign mem_raddr = iss_q[AW-1:0];
	assign sweep_end = (iss_q == cnt_q) && !rd_v_s1;
	always_comb begin
		issue_now = 1'b0;
		if (state_q == S_SCAN) begin
			issue_now = (iss_q < cnt_q) && !scan_hit;
		end else if (state_q == S_SHIFT) begin
			issue_now = (iss_q < cnt_q);
		end
	end

	// Memory write selection: append, rewrite in place, or shift down by one.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = hit_idx_q;
		mem_wdata = '{key: key_q, name: name_q};
		if (state_q == S_DECIDE) begin
			if (act_q == ACT_ADD && !hit_q) begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[AW-1:0];
			end else if (act_q == ACT_UPD && hit_q && !clash_q) begin
				mem_we    = 1'b1;
				mem_wdata = '{key: nkey_q, name: name_q};
			end
		end else if (state_q == S_SHIFT && rd_v_s1) begin
			mem_we    = 1'b1;
			mem_waddr = rd_idx_s1 - AW'(1);
			mem_wdata = mem_rdata;
		end
	end

	// Sequencer, table count, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cap_q     <= CFG_RESET;
			cnt_q     <= '0;
			iss_q     <= '0;
			rd_v_s1   <= 1'b0;
			hit_q     <= 1'b0;
			clash_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (m_valid_q && m_axis_tready && state_q != S_DONE) begin
				m_valid_q <= 1'b0;
			end
			rd_v_s1   <= issue_now;
			rd_idx_s1 <= mem_raddr;
			if (issue_now) begin
				iss_q <= iss_q + CW'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						act_q   <= action_t'(s_axis_tuser);
						key_q   <= s_axis_tdata[KEY_W-1:0];
						nkey_q  <= s_axis_tdata[2*KEY_W-1:KEY_W];
						name_q  <= s_axis_tdata[IN_DATA_W-1:2*KEY_W];
						hit_q   <= 1'b0;
						clash_q <= 1'b0;
						iss_q   <= '0;
						if (action_t'(s_axis_tuser) == ACT_ADD && table_full) begin
							res_status_q <= ST_FULL;
							res_name_q   <= '0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						hit_q     <= 1'b1;
						hit_idx_q <= rd_idx_s1;
						found_q   <= mem_rdata.name;
						state_q   <= S_DECIDE;
					end else begin
						// Update keeps the first key match as target; any other
						// entry holding the new key is a clash.
						if (rd_v_s1 && act_q == ACT_UPD) begin
							if (!hit_q && key_eq) begin
								hit_q     <= 1'b1;
								hit_idx_q <= rd_idx_s1;
							end else if (nkey_eq) begin
								clash_q <= 1'b1;
							end
						end
						if (sweep_end) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					unique case (act_q)
						ACT_ADD: begin
							res_name_q <= '0;
							state_q    <= S_DONE;
							if (hit_q) begin
								res_status_q <= ST_DUP;
							end else begin
								res_status_q <= ST_OK;
								cnt_q        <= cnt_q + CW'(1);
							end
						end
						ACT_DEL: begin
							res_name_q <= '0;
							if (hit_q) begin
								res_status_q <= ST_OK;
								iss_q        <= CW'(hit_idx_q) + CW'(1);
								state_q      <= S_SHIFT;
							end else begin
								res_status_q <= ST_NOT_FOUND;
								state_q      <= S_DONE;
							end
						end
						ACT_GET: begin
							state_q <= S_DONE;
							if (hit_q) begin
								res_status_q <= ST_OK;
								res_name_q   <= found_q;
							end else begin
								res_status_q <= ST_NOT_FOUND;
								res_name_q   <= '0;
							end
						end
						ACT_UPD: begin
							res_name_q <= '0;
							state_q    <= S_DONE;
							if (clash_q) begin
								res_status_q <= ST_UPD_CLASH;
							end else if (!hit_q) begin
								res_status_q <= ST_UPD_MISSING;
							end else begin
								res_status_q <= ST_OK;
							end
						end
						default: begin
							res_name_q   <= '0;
							res_status_q <= ST_NOT_FOUND;
							state_q      <= S_DONE;
						end
					endcase
				end
				S_SHIFT: begin
					if (sweep_end) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q  <= 1'b1;
						m_status_q <= res_status_q;
						m_name_q   <= res_name_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, m_name_q, m_status_q};

`ifndef SYNTHESIS
	// The entry count never exceeds the built capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// The count moves by at most one entry per word.
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
		(cnt_q == $past(cnt_q) + CW'(1) || cnt_q == $past(cnt_q) - CW'(1)))
		else $error("entry count jumped");

	// Every read in flight addresses a valid entry.
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (CW'(rd_idx_s1) < cnt_q))
		else $error("read beyond valid entries");

	// The table is never written while idle or while holding a finished result.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
		else $error("memory written outside an operation");
`endif

endmodule

>>> test/keyed_entry_table_core_tb.sv
// Self-checking testbench for the keyed entry table core: directed and random table traffic.
`timescale 1ns / 100ps

module keyed_entry_table_core_tb;
	import kvt_pkg::*;

	localparam int TABLE_DEPTH    = 64;
	localparam int RANDOM_ITEMS   = 1800;
	localparam int CALM_ITEMS     = 200;
	localparam int PHASE_ITEMS    = 100;
	localparam int POOL_SIZE      = 96;
	localparam int SETTLE_CYCLES  = 8;
	localparam int END_SLACK      = 150;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
	localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_NEG = 32'hFFFF_FFFF;

	// One expected result word.
	typedef struct packed {
		status_t           status;
		logic [NAME_W-1:0] name;
	} result_t;

	// Mirror of the table contents together with the results still owed by the block.
	class table_mirror;
		logic [KEY_W-1:0]  keys [TABLE_DEPTH];
		logic [NAME_W-1:0] names [TABLE_DEPTH];
		int unsigned       count;
		logic [CFG_W-1:0]  capacity_reg;
		result_t           awaited [$];
		int                failures;

		function new();
			count = 0;
			capacity_reg = CFG_RESET;
			failures = 0;
		endfunction

		// Position of the first valid entry holding the key, or count when absent.
		function int unsigned locate(logic [KEY_W-1:0] key);
			for (int unsigned i = 0; i < count; i++) begin
				if (keys[i] == key)
					return i;
			end
			return count;
		endfunction

		// Applies one accepted input word and queues the result it must produce.
		function void note_word(action_t act, logic [KEY_W-1:0] key, logic [KEY_W-1:0] nkey,
				logic [NAME_W-1:0] name);
			int unsigned limit;
			int unsigned idx;
			int unsigned target;
			bit          clash;
			result_t     res;
			limit = (capacity_reg > TABLE_DEPTH) ? TABLE_DEPTH : capacity_reg;
			res.status = ST_OK;
			res.name = '0;
			case (act)
				ACT_ADD: begin
					if (count >= limit) begin
						res.status = ST_FULL;
					end else if (locate(key) < count) begin
						res.status = ST_DUP;
					end else begin
						keys[count] = key;
						names[count] = name;
						count++;
					end
				end
				ACT_DEL: begin
					idx = locate(key);
					if (idx >= count) begin
						res.status = ST_NOT_FOUND;
					end else begin
						for (int unsigned i = idx; i + 1 < count; i++) begin
							keys[i] = keys[i + 1];
							names[i] = names[i + 1];
						end
						count--;
					end
				end
				ACT_GET: begin
					idx = locate(key);
					if (idx >= count)
						res.status = ST_NOT_FOUND;
					else
						res.name = names[idx];
				end
				default: begin
					// The first entry with the old key is the target; any other entry
					// holding the new key is a clash, which outranks a missing target.
					target = count;
					clash = 1'b0;
					for (int unsigned i = 0; i < count; i++) begin
						if (target == count && keys[i] == key)
							target = i;
						else if (keys[i] == nkey)
							clash = 1'b1;
					end
					if (clash) begin
						res.status = ST_UPD_CLASH;
					end else if (target >= count) begin
						res.status = ST_UPD_MISSING;
					end else begin
						keys[target] = nkey;
						names[target] = name;
					end
				end
			endcase
			awaited.push_back(res);
		endfunction

		// Compares one accepted result word with the oldest expectation.
		function void check_result(logic [OUT_DATA_W-1:0] word);
			result_t           want;
			logic [STATUS_W-1:0] got_status;
			logic [NAME_W-1:0] got_name;
			got_status = word[STATUS_W-1:0];
			got_name = word[STATUS_W +: NAME_W];
			if (awaited.size() == 0) begin
				$error("unexpected result word: status %0d, found_name %h", got_status, got_name);
				failures++;
				return;
			end
			want = awaited.pop_front();
			if (got_status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got_status);
				failures++;
			end
			if (got_name !== want.name) begin
				$error("found_name: expected %h, actual %h", want.name, got_name);
				failures++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_W-1:0]      cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [ACT_W-1:0]      s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	table_mirror       sb;
	bit                calm;
	int                items_sent;
	int                quiet = 0;
	int                pool_n;
	logic [KEY_W-1:0]  key_pool [POOL_SIZE];

	keyed_entry_table_core #(
		.CAPACITY(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		// From bit 0: entry_key, new_key, entry_name.
		.s_axis_tdata(s_axis_tdata),
		// From bit 0: action.
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		// From bit 0: status, found_name, zero padding.
		.m_axis_tdata(m_axis_tdata)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Both channels are observed at the clock edge, before any driver update lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_word(action_t'(s_axis_tuser), s_axis_tdata[KEY_W-1:0],
						s_axis_tdata[2*KEY_W-1:KEY_W], s_axis_tdata[IN_DATA_W-1:2*KEY_W]);
		end
	end

	// Watchdog: ends the run after too long without any word moving.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("keyed_entry_table_core_tb: errors");
				$finish;
			end
		end
	end

	// Result receiver: bursts of readiness, some preceded by stalls; no stalls once calm.
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	// Offers one input word, after an optional idle burst, and waits for its acceptance.
	task automatic send_word(action_t act, logic [KEY_W-1:0] key, logic [KEY_W-1:0] nkey,
			logic [NAME_W-1:0] name);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {name, nkey, key};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// Waits until every owed result has arrived and the sequencer has gone quiet.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the capacity register while the block is idle.
	task automatic write_capacity(logic [CFG_W-1:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.capacity_reg = value;
	endtask

	// Keys mostly come from a small pool so that hits, duplicates and clashes are common.
	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 15) == 0)
			return $urandom;
		return key_pool[$urandom_range(0, pool_n - 1)];
	endfunction

	function automatic logic [NAME_W-1:0] pick_name();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// One random word; the share of adds decides how far the table fills.
	task automatic send_random_word(int add_pct);
		int      r;
		action_t act;
		r = $urandom_range(0, 99);
		if (r < add_pct)
			act = ACT_ADD;
		else
			case (r % 3)
				0: act = ACT_DEL;
				1: act = ACT_GET;
				default: act = ACT_UPD;
			endcase
		send_word(act, pick_key(), pick_key(), pick_name());
	endtask

	// Directed part: empty table, extreme keys, every operation and the corner cases.
	task automatic run_directed();
		send_word(ACT_GET, 32'd0, 32'd0, '0);
		send_word(ACT_DEL, 32'd0, 32'd0, '0);
		send_word(ACT_UPD, 32'd5, 32'd6, '1);
		send_word(ACT_ADD, KEY_MIN, KEY_MAX, '1);
		send_word(ACT_ADD, KEY_MAX, KEY_MIN, '0);
		send_word(ACT_ADD, 32'd0, 32'd0, 64'hA5A5_A5A5_5A5A_5A5A);
		// Duplicate key on add.
		send_word(ACT_ADD, 32'd0, 32'd0, 64'h1111_2222_3333_4444);
		send_word(ACT_GET, KEY_MIN, 32'd0, '0);
		send_word(ACT_GET, KEY_MAX, 32'd0, '0);
		// New key already held by another entry.
		send_word(ACT_UPD, 32'd0, KEY_MAX, 64'hDEAD_BEEF_0000_0001);
		// Clash wins even when the target key is absent.
		send_word(ACT_UPD, 32'd12345, KEY_MIN, 64'hDEAD_BEEF_0000_0002);
		// Rekeying to the same key is not a clash.
		send_word(ACT_UPD, 32'd0, 32'd0, 64'h0123_4567_89AB_CDEF);
		send_word(ACT_UPD, 32'd0, KEY_NEG, 64'hFEDC_BA98_7654_3210);
		send_word(ACT_UPD, 32'd77, 32'd78, '0);
		// Deleting the first entry shifts the rest down.
		send_word(ACT_DEL, KEY_MIN, 32'd0, '0);
		send_word(ACT_GET, KEY_NEG, 32'd0, '0);
		// A zero limit refuses every add.
		write_capacity(7'd0);
		send_word(ACT_ADD, 32'd5, 32'd0, '1);
		// A limit below the count keeps the entries but refuses adds.
		write_capacity(7'd1);
		send_word(ACT_ADD, 32'd5, 32'd0, '1);
		send_word(ACT_DEL, KEY_NEG, 32'd0, '0);
		send_word(ACT_ADD, 32'd5, 32'd0, '1);
		send_word(ACT_DEL, KEY_MAX, 32'd0, '0);
		send_word(ACT_ADD, 32'd5, 32'd0, 64'h5555_AAAA_5555_AAAA);
		// Register values above the built capacity are clamped.
		write_capacity(7'd127);
		send_word(ACT_ADD, 32'd6, 32'd0, 64'hAAAA_5555_AAAA_5555);
	endtask

	// Main sequence: reset, directed part, random phases, drain and verdict.
	initial begin
		int               choice;
		int               add_pct;
		int               total;
		logic [CFG_W-1:0] cap;
		sb = new();
		calm = 1'b0;
		items_sent = 0;
		pool_n = 12;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= ACT_ADD;
		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = 32'd0;
		key_pool[3] = KEY_NEG;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		total = items_sent + RANDOM_ITEMS;

		// Random phases, each under its own capacity setting.
		while (items_sent < total) begin
			choice = $urandom_range(0, 15);
			if (choice == 0)
				cap = 7'd0;
			else if (choice < 6)
				cap = CFG_W'($urandom_range(1, 8));
			else if (choice < 10)
				cap = 7'd64;
			else if (choice < 12)
				cap = 7'd127;
			else
				cap = CFG_W'($urandom_range(0, 127));
			write_capacity(cap);
			pool_n = (cap <= 8) ? 12 : $urandom_range(8, POOL_SIZE);
			add_pct = $urandom_range(25, 70);
			repeat (PHASE_ITEMS) begin
				if (items_sent >= total - CALM_ITEMS)
					calm = 1'b1;
				send_random_word(add_pct);
			end
		end

		settle();
		repeat (END_SLACK) @(posedge clk);
		if (sb.awaited.size() != 0) begin
			$error("%0d expected result words never arrived", sb.awaited.size());
			sb.failures++;
		end
		if (sb.failures == 0)
			$display("keyed_entry_table_core_tb: clean");
		else
			$display("keyed_entry_table_core_tb: errors");
		$finish;
	end

endmodule
